@@ hw/rtl/cspu_pkg.sv @@
// Package for the chmod change-string parser: payload structs, parser state,
// character codes and the mask update helper. No dependencies.
package cspu_pkg;

  // Permission masks, octal layout sugo rwx
  localparam logic [11:0] FullMask    = 12'o7777;
  localparam logic [11:0] UgoMask     = 12'o0777;
  localparam logic [11:0] SetidSticky = 12'o7000;
  localparam logic [11:0] WhoU        = 12'o4700;
  localparam logic [11:0] WhoG        = 12'o2070;
  localparam logic [11:0] WhoO        = 12'o1007;
  localparam logic [11:0] PermR       = 12'o0444;
  localparam logic [11:0] PermW       = 12'o0222;
  localparam logic [11:0] PermX       = 12'o0111;
  localparam logic [11:0] PermS       = 12'o6000;
  localparam logic [11:0] PermT       = 12'o1000;
  localparam logic [2:0]  DigitSat    = 3'd5;

  // ASCII codes
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChEqual = 8'h3d;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChU     = 8'h75;
  localparam logic [7:0] ChG     = 8'h67;
  localparam logic [7:0] ChO     = 8'h6f;
  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChW     = 8'h77;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChS     = 8'h73;
  localparam logic [7:0] ChT     = 8'h74;

  typedef enum logic [1:0] {
    OP_PLUS  = 2'd0,
    OP_MINUS = 2'd1,
    OP_EQUAL = 2'd2
  } op_e;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } cspu_in_t;

  typedef struct packed {
    logic        valid_res;
    logic [11:0] new_bits;
    logic [11:0] change_mask;
  } cspu_out_t;

  typedef struct packed {
    logic        at_start;
    logic        octal_form;
    logic        failed;
    logic [11:0] octal_value;
    logic [2:0]  digit_count;
    logic        in_perm_phase;
    logic [11:0] who_mask;
    op_e         pending_op;
    logic [11:0] pending_bits;
    logic [11:0] acc_bits;
    logic [11:0] acc_mask;
  } cspu_state_t;

  localparam cspu_state_t StateReset = '{
    at_start: 1'b1, octal_form: 1'b0, failed: 1'b0, octal_value: 12'd0,
    digit_count: 3'd0, in_perm_phase: 1'b0, who_mask: 12'd0,
    pending_op: OP_PLUS, pending_bits: 12'd0, acc_bits: 12'd0, acc_mask: 12'd0
  };

  typedef struct packed {
    logic [11:0] bits;
    logic [11:0] mask;
  } cspu_acc_t;

  // Fold the pending operator into the accumulated bits and mask
  function automatic cspu_acc_t apply_op(op_e op, logic [11:0] pend, logic [11:0] who,
                                         logic [11:0] bits, logic [11:0] mask);
    cspu_acc_t   r;
    logic [11:0] sel;
    sel = pend & who;
    case (op)
      OP_PLUS: begin
        r.mask = mask | sel;
        r.bits = bits | sel;
      end
      OP_MINUS: begin
        r.mask = mask | sel;
        r.bits = bits & ~sel;
      end
      default: begin
        r.mask = mask | who;
        r.bits = (bits & ~who) | sel;
      end
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/cspu_step.sv @@
// Next-state and result logic for one character of a chmod change string.
// Depends on cspu_pkg.
module cspu_step (
  input  cspu_pkg::cspu_state_t state_i,
  input  cspu_pkg::cspu_in_t    char_i,
  output cspu_pkg::cspu_state_t state_o,
  output cspu_pkg::cspu_out_t   res_o
);

  cspu_pkg::cspu_state_t s;
  cspu_pkg::cspu_acc_t   acc;
  cspu_pkg::cspu_acc_t   fin;
  logic [7:0]            c;
  logic                  is_digit;
  logic                  is_op;
  cspu_pkg::op_e         op;

  assign c        = char_i.character;
  assign is_digit = (c >= cspu_pkg::ChZero) && (c <= cspu_pkg::ChSeven);
  assign is_op    = (c == cspu_pkg::ChPlus) || (c == cspu_pkg::ChMinus) ||
                    (c == cspu_pkg::ChEqual);

  // Operator decode
  always_comb begin
    case (c)
      cspu_pkg::ChMinus: op = cspu_pkg::OP_MINUS;
      cspu_pkg::ChEqual: op = cspu_pkg::OP_EQUAL;
      default:           op = cspu_pkg::OP_PLUS;
    endcase
  end

  // Pending operator folded in, used on ',' and on a chained operator
  assign acc = cspu_pkg::apply_op(state_i.pending_op, state_i.pending_bits,
                                  state_i.who_mask, state_i.acc_bits, state_i.acc_mask);

  // Per-character state update
  always_comb begin
    s = state_i;
    if (state_i.at_start) begin
      s.at_start   = 1'b0;
      s.octal_form = is_digit;
    end
    if (!state_i.failed) begin
      if (s.octal_form) begin
        if (!is_digit) begin
          s.failed = 1'b1;
        end else begin
          if (state_i.octal_value[11:9] != 3'd0) s.failed = 1'b1;
          s.octal_value = {state_i.octal_value[8:0], c[2:0]};
          if (state_i.digit_count < cspu_pkg::DigitSat) begin
            s.digit_count = state_i.digit_count + 3'd1;
          end
        end
      end else if (!state_i.in_perm_phase) begin
        case (c)
          cspu_pkg::ChU: s.who_mask = state_i.who_mask | cspu_pkg::WhoU;
          cspu_pkg::ChG: s.who_mask = state_i.who_mask | cspu_pkg::WhoG;
          cspu_pkg::ChO: s.who_mask = state_i.who_mask | cspu_pkg::WhoO;
          cspu_pkg::ChA: s.who_mask = cspu_pkg::FullMask;
          default: begin
            if (!is_op) begin
              s.failed = 1'b1;
            end else begin
              // no who letters means all
              if (state_i.who_mask == 12'd0) s.who_mask = cspu_pkg::FullMask;
              s.pending_op    = op;
              s.pending_bits  = 12'd0;
              s.in_perm_phase = 1'b1;
            end
          end
        endcase
      end else begin
        case (c)
          cspu_pkg::ChR: s.pending_bits = state_i.pending_bits | cspu_pkg::PermR;
          cspu_pkg::ChW: s.pending_bits = state_i.pending_bits | cspu_pkg::PermW;
          cspu_pkg::ChX: s.pending_bits = state_i.pending_bits | cspu_pkg::PermX;
          cspu_pkg::ChS: s.pending_bits = state_i.pending_bits | cspu_pkg::PermS;
          cspu_pkg::ChT: s.pending_bits = state_i.pending_bits | cspu_pkg::PermT;
          default: begin
            if (is_op) begin
              s.acc_bits     = acc.bits;
              s.acc_mask     = acc.mask;
              s.pending_op   = op;
              s.pending_bits = 12'd0;
            end else if (c == cspu_pkg::ChComma) begin
              s.acc_bits      = acc.bits;
              s.acc_mask      = acc.mask;
              s.who_mask      = 12'd0;
              s.pending_bits  = 12'd0;
              s.pending_op    = cspu_pkg::OP_PLUS;
              s.in_perm_phase = 1'b0;
            end else begin
              s.failed = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Closing fold for the final segment
  assign fin = cspu_pkg::apply_op(s.pending_op, s.pending_bits, s.who_mask,
                                  s.acc_bits, s.acc_mask);

  // Result on the last character; state returns to reset after it
  always_comb begin
    res_o = '0;
    if (!s.failed) begin
      if (s.octal_form) begin
        res_o.valid_res = 1'b1;
        res_o.new_bits  = s.octal_value;
        res_o.change_mask =
          ((s.digit_count >= cspu_pkg::DigitSat) ||
           ((s.octal_value & cspu_pkg::SetidSticky) != 12'd0)) ?
          cspu_pkg::FullMask : cspu_pkg::UgoMask;
      end else if (s.in_perm_phase) begin
        res_o.valid_res   = 1'b1;
        res_o.new_bits    = fin.bits;
        res_o.change_mask = fin.mask;
      end
    end
    state_o = char_i.last_char ? cspu_pkg::StateReset : s;
  end

endmodule

@@ hw/rtl/chmod_spec_parser_unit.sv @@
// Top level of the chmod change-string parser: input register, parser state
// register and result register around cspu_step. Depends on cspu_pkg and cspu_step.
//
//   channel | direction | payload              | handshake
//   --------+-----------+----------------------+------------------------
//   in      | input     | cspu_pkg::cspu_in_t  | in_valid_i / in_stall_o
//   out     | output    | cspu_pkg::cspu_out_t | out_valid_o / out_stall_i
//
// One character per cycle unless the input stalls. A character is registered on
// accept and decoded in the next cycle against the parser state register; on the
// last character the result register loads from that decode once it is free to
// take it. The result register lets the next string's characters flow in while a
// result waits. Reset puts the parser at the start of a string; input stalls only
// while a last character waits on a full, stalled result register.
module chmod_spec_parser_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cspu_pkg::cspu_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cspu_pkg::cspu_out_t out_data_o
);

  logic                  in_valid_q;
  cspu_pkg::cspu_in_t    in_q;
  cspu_pkg::cspu_state_t state_q, state_d;
  logic                  out_valid_q;
  cspu_pkg::cspu_out_t   out_q;
  cspu_pkg::cspu_out_t   res;
  logic                  out_free;
  logic                  proc;

  cspu_step u_step (
    .state_i (state_q),
    .char_i  (in_q),
    .state_o (state_d),
    .res_o   (res)
  );

  // Registered character may advance unless its result has nowhere to go
  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && (!in_q.last_char || out_free);
  assign in_stall_o = in_valid_q && !proc;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cspu_pkg::StateReset;
    end else if (proc) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && in_q.last_char) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && in_q.last_char) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ dv/chmod_spec_parser_unit_tb.sv @@
// Self-checking testbench for chmod_spec_parser_unit: directed and random change strings,
// checked against a mode scoreboard that mirrors the parser. Depends on cspu_pkg
// and the chmod_spec_parser_unit RTL.
module chmod_spec_parser_unit_tb;

  typedef logic [7:0] text_q_t[$];

  localparam int IdleLimit   = 4000;
  localparam int DrainCycles = 20;
  localparam int MaxPrinted  = 40;

  // Parser mirror plus the queue of modes still owed by the block
  class mode_scoreboard;
    logic                 at_start;
    logic                 octal_form;
    logic                 failed;
    logic [11:0]          oct_value;
    logic [2:0]           digits;
    logic                 perm_phase;
    logic [11:0]          who;
    cspu_pkg::op_e        pend_op;
    logic [11:0]          pend_bits;
    logic [11:0]          acc_bits;
    logic [11:0]          acc_mask;
    cspu_pkg::cspu_out_t  owed_modes[$];
    int                   errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      at_start   = 1'b1;
      octal_form = 1'b0;
      failed     = 1'b0;
      oct_value  = '0;
      digits     = '0;
      perm_phase = 1'b0;
      who        = '0;
      pend_op    = cspu_pkg::OP_PLUS;
      pend_bits  = '0;
      acc_bits   = '0;
      acc_mask   = '0;
    endfunction

    // Fold the open operator into the accumulated bits and mask
    function void fold_pending();
      logic [11:0] sel;
      sel = pend_bits & who;
      case (pend_op)
        cspu_pkg::OP_PLUS: begin
          acc_mask |= sel;
          acc_bits |= sel;
        end
        cspu_pkg::OP_MINUS: begin
          acc_mask |= sel;
          acc_bits &= ~sel;
        end
        default: begin
          acc_mask |= who;
          acc_bits = (acc_bits & ~who) | sel;
        end
      endcase
    endfunction

    // Step the mirror on one accepted character; a last character owes a mode
    function void note_char(cspu_pkg::cspu_in_t item);
      logic [7:0]          ch;
      logic                is_op;
      cspu_pkg::op_e       op;
      cspu_pkg::cspu_out_t mode;
      ch    = item.character;
      is_op = 1'b1;
      op    = cspu_pkg::OP_PLUS;
      case (ch)
        cspu_pkg::ChPlus:  op = cspu_pkg::OP_PLUS;
        cspu_pkg::ChMinus: op = cspu_pkg::OP_MINUS;
        cspu_pkg::ChEqual: op = cspu_pkg::OP_EQUAL;
        default:           is_op = 1'b0;
      endcase
      if (at_start) begin
        at_start   = 1'b0;
        octal_form = (ch >= cspu_pkg::ChZero) && (ch <= cspu_pkg::ChSeven);
      end
      if (!failed && octal_form) begin
        if (ch < cspu_pkg::ChZero || ch > cspu_pkg::ChSeven) begin
          failed = 1'b1;
        end else begin
          // a nonzero digit pushed out of the window is an overflow
          if (oct_value[11:9] != 3'd0) failed = 1'b1;
          oct_value = {oct_value[8:0], ch[2:0]};
          if (digits < cspu_pkg::DigitSat) digits++;
        end
      end else if (!failed && !perm_phase) begin
        case (ch)
          cspu_pkg::ChU: who |= cspu_pkg::WhoU;
          cspu_pkg::ChG: who |= cspu_pkg::WhoG;
          cspu_pkg::ChO: who |= cspu_pkg::WhoO;
          cspu_pkg::ChA: who |= cspu_pkg::FullMask;
          default: begin
            if (!is_op) begin
              failed = 1'b1;
            end else begin
              if (who == '0) who = cspu_pkg::FullMask;
              pend_op    = op;
              pend_bits  = '0;
              perm_phase = 1'b1;
            end
          end
        endcase
      end else if (!failed) begin
        case (ch)
          cspu_pkg::ChR: pend_bits |= cspu_pkg::PermR;
          cspu_pkg::ChW: pend_bits |= cspu_pkg::PermW;
          cspu_pkg::ChX: pend_bits |= cspu_pkg::PermX;
          cspu_pkg::ChS: pend_bits |= cspu_pkg::PermS;
          cspu_pkg::ChT: pend_bits |= cspu_pkg::PermT;
          cspu_pkg::ChComma: begin
            fold_pending();
            who        = '0;
            pend_bits  = '0;
            pend_op    = cspu_pkg::OP_PLUS;
            perm_phase = 1'b0;
          end
          default: begin
            if (is_op) begin
              fold_pending();
              pend_op   = op;
              pend_bits = '0;
            end else begin
              failed = 1'b1;
            end
          end
        endcase
      end
      if (item.last_char) begin
        mode = '0;
        if (!failed && octal_form) begin
          mode.valid_res   = 1'b1;
          mode.new_bits    = oct_value;
          mode.change_mask = (digits >= cspu_pkg::DigitSat ||
                              (oct_value & cspu_pkg::SetidSticky) != '0) ?
                             cspu_pkg::FullMask : cspu_pkg::UgoMask;
        end else if (!failed && perm_phase) begin
          fold_pending();
          mode.valid_res   = 1'b1;
          mode.new_bits    = acc_bits;
          mode.change_mask = acc_mask;
        end
        owed_modes.push_back(mode);
        restart();
      end
    endfunction

    task report(string msg);
      if (errors < MaxPrinted) $display("%0t: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_mode(cspu_pkg::cspu_out_t got);
      cspu_pkg::cspu_out_t want;
      if (owed_modes.size() == 0) begin
        report($sformatf("result %0b/%o/%o with none expected",
                         got.valid_res, got.new_bits, got.change_mask));
      end else begin
        want = owed_modes.pop_front();
        if (got.valid_res !== want.valid_res)
          report($sformatf("valid_res got %0b expected %0b", got.valid_res, want.valid_res));
        if (got.new_bits !== want.new_bits)
          report($sformatf("new_bits got %o expected %o", got.new_bits, want.new_bits));
        if (got.change_mask !== want.change_mask)
          report($sformatf("change_mask got %o expected %o",
                           got.change_mask, want.change_mask));
      end
    endtask

    function int outstanding();
      return owed_modes.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  cspu_pkg::cspu_in_t  in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  cspu_pkg::cspu_out_t out_data_o;

  int send_idle_pct;
  int recv_stall_pct;
  int idle_cycles = 0;

  mode_scoreboard modes = new();

  chmod_spec_parser_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Clock, period 4
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: every accepted transaction on either channel goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) modes.note_char(in_data_i);
      if (out_valid_o && !out_stall_i) modes.check_mode(out_data_o);
    end
  end

  // Watchdog on cycles with no transaction at all
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
        $display("chmod_spec_parser_unit_tb: done, errors");
        $finish;
      end
    end
  end

  function automatic text_q_t from_ascii(string s);
    text_q_t text;
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    return text;
  endfunction

  // One character; valid stays up between back-to-back transactions
  task automatic send_char(input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{character: ch, last_char: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_text(input text_q_t text);
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
  endtask

  // Hold off input until every owed mode has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (modes.outstanding() != 0);
  endtask

  // Random strings: mostly well-formed octal and symbolic, some broken, some noise
  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_chars);
    text_q_t    text;
    logic [7:0] ch;
    int         sent;
    int         kind;
    int         n;
    sent           = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < n_chars) begin
      text.delete();
      kind = $urandom_range(99);
      if (kind < 35) begin
        n = ($urandom_range(4) == 0) ? $urandom_range(6, 5) : $urandom_range(4, 1);
        for (int i = 0; i < n; i++) begin
          // long strings mostly keep their leading places zero
          if (i < n - 4 && $urandom_range(4) != 0) text.push_back(cspu_pkg::ChZero);
          else text.push_back(cspu_pkg::ChZero + 8'($urandom_range(7)));
        end
      end else if (kind < 85) begin
        for (int seg = 0; seg < $urandom_range(3, 1); seg++) begin
          if (seg > 0) text.push_back(cspu_pkg::ChComma);
          for (int w = 0; w < $urandom_range(3); w++) begin
            case ($urandom_range(3))
              0:       ch = cspu_pkg::ChU;
              1:       ch = cspu_pkg::ChG;
              2:       ch = cspu_pkg::ChO;
              default: ch = cspu_pkg::ChA;
            endcase
            text.push_back(ch);
          end
          for (int o = 0; o < $urandom_range(2, 1); o++) begin
            case ($urandom_range(2))
              0:       ch = cspu_pkg::ChPlus;
              1:       ch = cspu_pkg::ChMinus;
              default: ch = cspu_pkg::ChEqual;
            endcase
            text.push_back(ch);
            for (int p = 0; p < $urandom_range(3); p++) begin
              case ($urandom_range(4))
                0:       ch = cspu_pkg::ChR;
                1:       ch = cspu_pkg::ChW;
                2:       ch = cspu_pkg::ChX;
                3:       ch = cspu_pkg::ChS;
                default: ch = cspu_pkg::ChT;
              endcase
              text.push_back(ch);
            end
          end
        end
      end else begin
        for (int i = 0; i < $urandom_range(4, 1); i++) text.push_back(8'($urandom_range(255)));
      end
      // break some of the well-formed strings
      if (kind < 85 && $urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0:       text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
          1:       text.push_back(cspu_pkg::ChComma);
          default: text.push_front(cspu_pkg::ChComma);
        endcase
      end
      send_text(text);
      sent += text.size();
    end
    drain();
  endtask

  // Main sequence
  initial begin
    text_q_t text;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    send_idle_pct  = 34;
    recv_stall_pct = 81;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: octal extremes, overflow, digit count, bad digit
    send_text(from_ascii("7777"));
    send_text(from_ascii("17777"));
    send_text(from_ascii("00017"));
    send_text(from_ascii("7a"));
    // trailing comma, bare '=', chained operators
    send_text(from_ascii("a=,"));
    send_text(from_ascii("g="));
    send_text(from_ascii("+t-s"));
    // all-ones byte in the who phase, zero byte in the permission phase
    text = '{8'hff};
    send_text(text);
    text = from_ascii("+");
    text.push_back(8'h00);
    send_text(text);
    drain();

    run_phase(34, 81, 470);
    run_phase(81, 34, 470);
    run_phase(0, 0, 470);

    repeat (DrainCycles) @(posedge clk_i);
    if (modes.errors == 0) begin
      $display("chmod_spec_parser_unit_tb: done, clean");
    end else begin
      $display("chmod_spec_parser_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
